// File: src/scac_pkg.sv
// Package: widths and types shared by the crack crossing block.
package scac_pkg;
  localparam int MaxCracks = 16;
  localparam int CoordBits = 16;
  localparam int SlotBits = $clog2(MaxCracks);
  localparam int CountBits = 5;
  localparam int DiffBits = CoordBits + 1;
  localparam int ProdBits = 2 * DiffBits;
  localparam int DetBits = ProdBits + 1;

  typedef logic signed [CoordBits-1:0] coord_t;

  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
  } seg_t;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_QUERY = 1'b1;
endpackage

// File: src/segment_crosses_any_crack.sv
// Top level: crack table held in a chain of cells, bond crossing query.
// Channels: in_* carries a word (operation, slot, two endpoints) under
// in_valid/in_stall; out_* returns one word (crossed, was_query) under
// out_valid/out_stall. cfg_we/cfg_data set crack_count; the user must write it
// only while idle, the block does not enforce this. A load writes the crack into
// its cell directly and is acknowledged in the next cycle. A query walks the 16
// cells, one cell per cycle, and its result is registered after the last cell.
// One word is in flight at a time; a new word is accepted once the result
// register is empty or being taken in the same cycle.
// crack_count above 16 acts as 16; only cells below the count may hit.
// Reset clears the count, the chain valid bits and the output register;
// crack contents are undefined until loaded.
// While out_stall is high with a result waiting, the result holds and no new word is accepted.
module segment_crosses_any_crack import scac_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic in_operation,
  input  logic [3:0] in_slot,
  input  logic signed [CoordBits-1:0] in_first_x,
  input  logic signed [CoordBits-1:0] in_first_y,
  input  logic signed [CoordBits-1:0] in_second_x,
  input  logic signed [CoordBits-1:0] in_second_y,
  output logic out_valid,
  input  logic out_stall,
  output logic out_crossed,
  output logic out_was_query,
  input  logic cfg_we,
  input  logic [CountBits-1:0] cfg_data
);
  logic [CountBits-1:0] count_r;
  logic busy_r, out_vld_r, crossed_r, was_q_r;
  logic acc;
  seg_t in_seg;
  logic vld_c [MaxCracks+1];
  seg_t bond_c [MaxCracks+1];
  logic act_c [MaxCracks+1];
  logic hit_c [MaxCracks+1];
  logic [CountBits:0] n_eff;

  assign in_seg = '{in_first_x, in_first_y, in_second_x, in_second_y};
  assign in_stall = busy_r || (out_vld_r && out_stall);
  assign acc = in_valid && !in_stall;
  assign n_eff = (count_r > CountBits'(MaxCracks)) ? (CountBits+1)'(MaxCracks)
                                                   : (CountBits+1)'(count_r);

  assign vld_c[0] = acc && (in_operation == OP_QUERY);
  assign bond_c[0] = in_seg;
  assign act_c[0] = 1'b1;
  assign hit_c[0] = 1'b0;

  for (genvar i = 0; i < MaxCracks; i++) begin : g_cell
    scac_cell u_cell (
      .clk(clk), .rst_n(rst_n),
      .ld_en(acc && (in_operation == OP_LOAD) && (in_slot == SlotBits'(i))),
      .ld_seg(in_seg),
      .bond_vld(vld_c[i]), .bond_in(bond_c[i]),
      .act_in(act_c[i] && ((CountBits+1)'(i) < n_eff)),
      .hit_in(hit_c[i]),
      .bond_vld_out(vld_c[i+1]), .bond_out(bond_c[i+1]),
      .act_out(act_c[i+1]), .hit_out(hit_c[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      busy_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_we) count_r <= cfg_data;
      if (out_vld_r && !out_stall) out_vld_r <= 1'b0;
      if (acc && in_operation == OP_QUERY) busy_r <= 1'b1;
      if (acc && in_operation == OP_LOAD) begin
        out_vld_r <= 1'b1;
        crossed_r <= 1'b0;
        was_q_r <= 1'b0;
      end
      if (vld_c[MaxCracks]) begin
        busy_r <= 1'b0;
        out_vld_r <= 1'b1;
        crossed_r <= hit_c[MaxCracks];
        was_q_r <= 1'b1;
      end
    end
  end

  assign out_valid = out_vld_r;
  assign out_crossed = crossed_r;
  assign out_was_query = was_q_r;

`ifndef NO_ASSERTIONS
  a_no_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !acc) else $error("word accepted while query in flight");
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    vld_c[MaxCracks] |-> busy_r) else $error("chain result without query");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    vld_c[MaxCracks] |-> !(out_vld_r && out_stall)) else $error("result overwritten");
  a_load_ack: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_operation == OP_LOAD) |=> (out_valid && !out_was_query && !out_crossed))
    else $error("load not acknowledged");
`endif
endmodule

// File: src/scac_cell.sv
// One cell of the crack chain: holds one crack, tests it against the passing bond.
module scac_cell import scac_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic ld_en,
  input  seg_t ld_seg,
  input  logic bond_vld,
  input  seg_t bond_in,
  input  logic act_in,
  input  logic hit_in,
  output logic bond_vld_out,
  output seg_t bond_out,
  output logic act_out,
  output logic hit_out
);
  seg_t crack_r;
  logic vld_r, act_r, hit_r;
  seg_t bond_r;
  logic signed [DiffBits-1:0] ux, uy, vx, vy, wx, wy;
  logic signed [DetBits-1:0] d, d1, d2;
  logic t_ok, s_ok, b1, b2, b3, pair_hit;

  function automatic logic unit_ok(input logic signed [DetBits-1:0] n,
                                   input logic signed [DetBits-1:0] dd);
    logic r;
    if (dd > 0) r = (n >= 0) && (n <= dd);
    else if (dd < 0) r = (n <= 0) && (n >= dd);
    else r = 1'b0;
    return r;
  endfunction

  function automatic logic in_box(input coord_t x, input coord_t y, input coord_t x0,
                                  input coord_t y0, input coord_t x1, input coord_t y1);
    return (x0 <= x) && (x <= x1) && (y0 <= y) && (y <= y1);
  endfunction

  always_comb begin
    ux = DiffBits'(crack_r.bx) - DiffBits'(crack_r.ax);
    uy = DiffBits'(crack_r.by) - DiffBits'(crack_r.ay);
    vx = DiffBits'(bond_in.ax) - DiffBits'(bond_in.bx);
    vy = DiffBits'(bond_in.ay) - DiffBits'(bond_in.by);
    wx = DiffBits'(bond_in.ax) - DiffBits'(crack_r.ax);
    wy = DiffBits'(bond_in.ay) - DiffBits'(crack_r.ay);
    d  = DetBits'(ux * vy) - DetBits'(uy * vx);
    d1 = DetBits'(wx * vy) - DetBits'(wy * vx);
    d2 = DetBits'(ux * wy) - DetBits'(uy * wx);
    t_ok = unit_ok(d1, d);
    s_ok = unit_ok(d2, d);
    b1 = in_box(bond_in.ax, bond_in.ay, crack_r.ax, crack_r.ay, crack_r.bx, crack_r.by);
    b2 = in_box(bond_in.bx, bond_in.by, crack_r.ax, crack_r.ay, crack_r.bx, crack_r.by);
    b3 = in_box(crack_r.ax, crack_r.ay, bond_in.ax, bond_in.ay, bond_in.bx, bond_in.by);
    pair_hit = (t_ok && s_ok) || b1 || b2 || b3;
  end

  always_ff @(posedge clk) begin
    if (ld_en) crack_r <= ld_seg;
    bond_r <= bond_in;
    act_r <= act_in;
    hit_r <= hit_in || (act_in && pair_hit);
    if (!rst_n) vld_r <= 1'b0;
    else vld_r <= bond_vld;
  end

  assign bond_vld_out = vld_r;
  assign bond_out = bond_r;
  assign act_out = act_r;
  assign hit_out = hit_r;
endmodule
